>>> rtl/terminal_line_editor_assert.svh
// Assertion macros for the line editor; they assume clock and reset in scope.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define TLE_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define TLE_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TLE_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tle_pkg.sv
`default_nettype none
package tle_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
      logic       ready_flag;
   } rsp_type;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic [1:0] CSR_CANONICAL = 2'd0;
   localparam logic [1:0] CSR_ECHO      = 2'd1;
   localparam logic [1:0] CSR_FOCUSED   = 2'd2;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CH_INTR   = 8'h03;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UC_C   = 8'h43;
   localparam logic [7:0] CH_UC_D   = 8'h44;
   localparam logic [7:0] CH_UC_F   = 8'h46;
   localparam logic [7:0] CH_UC_H   = 8'h48;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_ESC,
      CLS_ENTER,
      CLS_ERASE,
      CLS_INTR,
      CLS_CLEAR,
      CLS_PRINT
   } cls_type;

   typedef struct packed {
      logic       canonical;
      logic       echo_on;
      logic       focused;
      logic       op;
      cls_type    cls;
      logic [7:0] char_code;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/tle_front.sv
`default_nettype none
module tle_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  tle_pkg::req_type  req_data,
   input  wire               csr_we,
   input  wire [1:0]         csr_index,
   input  wire               csr_wdata,
   output logic              cmd_valid,
   input  wire               cmd_ready,
   output tle_pkg::cmd_type  cmd
);

   logic canonical_ff, echo_ff, focused_ff;
   tle_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff;
   tle_pkg::cmd_type cls_cmd;
   logic             push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         canonical_ff <= 1'b1;
         echo_ff      <= 1'b1;
         focused_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            tle_pkg::CSR_CANONICAL: canonical_ff <= csr_wdata;
            tle_pkg::CSR_ECHO:      echo_ff      <= csr_wdata;
            tle_pkg::CSR_FOCUSED:   focused_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cls_cmd.canonical = canonical_ff;
      cls_cmd.echo_on   = echo_ff & focused_ff;
      cls_cmd.focused   = focused_ff;
      cls_cmd.op        = req_data.op;
      cls_cmd.char_code = req_data.char_code;
      if (req_data.char_code == tle_pkg::CH_ESC) begin
         cls_cmd.cls = tle_pkg::CLS_ESC;
      end else if (req_data.char_code == tle_pkg::CH_LF ||
                   req_data.char_code == tle_pkg::CH_CR) begin
         cls_cmd.cls = tle_pkg::CLS_ENTER;
      end else if (req_data.char_code == tle_pkg::CH_BS ||
                   req_data.char_code == tle_pkg::CH_DEL) begin
         cls_cmd.cls = tle_pkg::CLS_ERASE;
      end else if (req_data.char_code == tle_pkg::CH_INTR) begin
         cls_cmd.cls = tle_pkg::CLS_INTR;
      end else if (req_data.char_code == tle_pkg::CH_FF) begin
         cls_cmd.cls = tle_pkg::CLS_CLEAR;
      end else if (req_data.char_code >= tle_pkg::CH_SPACE &&
                   req_data.char_code < tle_pkg::CH_DEL) begin
         cls_cmd.cls = tle_pkg::CLS_PRINT;
      end else begin
         cls_cmd.cls = tle_pkg::CLS_OTHER;
      end
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid & req_ready;
   assign pop       = cmd_valid & cmd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/tle_back.sv
`default_nettype none
module tle_back #(
   parameter int BUF_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   output logic              cmd_ready,
   input  tle_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output tle_pkg::rsp_type  rsp_data
);

   `include "terminal_line_editor_assert.svh"

   localparam int IW = $clog2(BUF_DEPTH);
   localparam int BW = IW + 1;
   localparam int TW = $clog2(3 * BUF_DEPTH);

   localparam logic [1:0] ESC_NORMAL = 2'd0;
   localparam logic [1:0] ESC_AFTER  = 2'd1;
   localparam logic [1:0] ESC_SEQ    = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_COPY = 6'b000010,
      ST_PRE  = 6'b000100,
      ST_LINE = 6'b001000,
      ST_MID  = 6'b010000,
      ST_BS   = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [7:0]    line_ff [BUF_DEPTH];
   logic [7:0]    line_in [BUF_DEPTH];
   logic [7:0]    ring_ff [BUF_DEPTH];
   logic [IW-1:0] len_ff, len_in, cur_ff, cur_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [1:0]    esc_ff, esc_in;
   logic          rdy_ff, rdy_in;
   logic [2:0][7:0] pre_ff, pre_in;
   logic [1:0]    plen_ff, plen_in, pidx_ff, pidx_in;
   logic [IW-1:0] rep_ff, rep_in;
   logic [1:0]    kind_ff, kind_in;
   logic [IW-1:0] lidx_ff, lidx_in, lend_ff, lend_in;
   logic          mid_ff, mid_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic          out_valid_ff, out_valid_in;
   tle_pkg::rsp_type out_ff, out_in;

   logic          emit;
   logic [1:0]    emit_kind;
   logic [7:0]    emit_byte;
   logic          push_en;
   logic [7:0]    push_byte;
   logic [IW-1:0] head_nx;
   logic [7:0]    line_rd;

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
      ring_next = (p == IW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign line_rd   = line_ff[lidx_ff];
   assign head_nx   = ring_next(head_ff);
   assign cmd_ready = (st_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic          out_free;
      logic [IW-1:0] j_rep, n_step, new_tail;
      logic [BW-1:0] j_bs;
      logic          copy_go;
      logic [TW-1:0] total;

      st_in    = st_ff;
      line_in  = line_ff;
      len_in   = len_ff;
      cur_in   = cur_ff;
      tail_in  = tail_ff;
      esc_in   = esc_ff;
      rdy_in   = rdy_ff;
      pre_in   = pre_ff;
      plen_in  = plen_ff;
      pidx_in  = pidx_ff;
      rep_in   = rep_ff;
      kind_in  = kind_ff;
      lidx_in  = lidx_ff;
      lend_in  = lend_ff;
      mid_in   = mid_ff;
      rem_in   = rem_ff;
      emit      = 1'b0;
      emit_kind = tle_pkg::KIND_ECHO;
      emit_byte = 8'd0;
      push_en   = 1'b0;
      push_byte = line_rd;
      out_free  = ~out_valid_ff | rsp_ready;
      j_rep     = '0;
      j_bs      = '0;
      n_step    = '0;
      new_tail  = tail_ff;
      copy_go   = 1'b0;
      total     = '0;

      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               pre_in  = '0;
               plen_in = 2'd1;
               pidx_in = 2'd0;
               kind_in = tle_pkg::KIND_ECHO;
               lidx_in = '0;
               lend_in = '0;
               mid_in  = 1'b0;
               if (cmd.op == tle_pkg::OP_READ) begin
                  j_rep   = IW'(1);
                  kind_in = tle_pkg::KIND_EMPTY;
                  if (!(cmd.canonical && !rdy_ff)) begin
                     if (head_ff != tail_ff) begin
                        kind_in   = tle_pkg::KIND_READ;
                        pre_in[0] = ring_ff[tail_ff];
                        new_tail  = ring_next(tail_ff);
                     end
                     tail_in = new_tail;
                     if (cmd.canonical && new_tail == head_ff) begin
                        rdy_in = 1'b0;
                     end
                  end
               end else if (!cmd.canonical) begin
                  push_en   = 1'b1;
                  push_byte = cmd.char_code;
                  pre_in[0] = cmd.char_code;
                  j_rep     = (cmd.cls == tle_pkg::CLS_PRINT && cmd.echo_on) ? IW'(1) : '0;
               end else if (esc_ff == ESC_AFTER) begin
                  esc_in = (cmd.char_code == tle_pkg::CH_LBRACK) ? ESC_SEQ : ESC_NORMAL;
               end else if (esc_ff == ESC_SEQ) begin
                  esc_in    = ESC_NORMAL;
                  plen_in   = 2'd3;
                  pre_in[0] = tle_pkg::CH_ESC;
                  pre_in[1] = tle_pkg::CH_LBRACK;
                  pre_in[2] = tle_pkg::CH_UC_C;
                  case (cmd.char_code)
                     tle_pkg::CH_UC_C: begin
                        if (cur_ff < len_ff) begin
                           cur_in = cur_ff + 1'b1;
                           n_step = IW'(1);
                        end
                     end
                     tle_pkg::CH_UC_F: begin
                        n_step = len_ff - cur_ff;
                        cur_in = len_ff;
                     end
                     tle_pkg::CH_UC_D: begin
                        pre_in[2] = tle_pkg::CH_UC_D;
                        if (cur_ff != '0) begin
                           cur_in = cur_ff - 1'b1;
                           n_step = IW'(1);
                        end
                     end
                     tle_pkg::CH_UC_H: begin
                        pre_in[2] = tle_pkg::CH_UC_D;
                        n_step    = cur_ff;
                        cur_in    = '0;
                     end
                     default: ;
                  endcase
                  j_rep = cmd.echo_on ? n_step : '0;
               end else begin
                  esc_in = ESC_NORMAL;
                  case (cmd.cls)
                     tle_pkg::CLS_ESC: begin
                        esc_in = ESC_AFTER;
                     end
                     tle_pkg::CLS_ENTER: begin
                        if (len_ff < IW'(BUF_DEPTH - 1)) begin
                           line_in[len_ff] = tle_pkg::CH_LF;
                           len_in = len_ff + 1'b1;
                        end
                        cur_in    = '0;
                        rdy_in    = 1'b1;
                        copy_go   = 1'b1;
                        pre_in[0] = tle_pkg::CH_LF;
                        j_rep     = cmd.echo_on ? IW'(1) : '0;
                     end
                     tle_pkg::CLS_ERASE: begin
                        if (cur_ff != '0 && cur_ff <= len_ff) begin
                           for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                              if (i >= int'(cur_ff) - 1 && i < int'(len_ff) - 1) begin
                                 line_in[i] = line_ff[i+1];
                              end
                           end
                           len_in = len_ff - 1'b1;
                           cur_in = cur_ff - 1'b1;
                           if (cmd.echo_on) begin
                              pre_in[0] = tle_pkg::CH_BS;
                              j_rep     = IW'(1);
                              lidx_in   = cur_ff - 1'b1;
                              lend_in   = len_ff - 1'b1;
                              mid_in    = 1'b1;
                              j_bs      = BW'(len_ff - cur_ff) + 1'b1;
                           end
                        end
                     end
                     tle_pkg::CLS_INTR: begin
                        len_in    = '0;
                        cur_in    = '0;
                        plen_in   = 2'd3;
                        pre_in[0] = tle_pkg::CH_CARET;
                        pre_in[1] = tle_pkg::CH_UC_C;
                        pre_in[2] = tle_pkg::CH_LF;
                        j_rep     = cmd.echo_on ? IW'(1) : '0;
                     end
                     tle_pkg::CLS_CLEAR: begin
                        kind_in = tle_pkg::KIND_CLEAR;
                        j_rep   = cmd.focused ? IW'(1) : '0;
                     end
                     tle_pkg::CLS_PRINT: begin
                        if (len_ff < IW'(BUF_DEPTH - 1) && cur_ff <= len_ff) begin
                           for (int i = 1; i < BUF_DEPTH; i++) begin
                              if (i > int'(cur_ff) && i <= int'(len_ff)) begin
                                 line_in[i] = line_ff[i-1];
                              end
                           end
                           line_in[cur_ff] = cmd.char_code;
                           len_in = len_ff + 1'b1;
                           cur_in = cur_ff + 1'b1;
                           if (cmd.echo_on) begin
                              lidx_in = cur_ff;
                              lend_in = len_ff + 1'b1;
                              j_bs    = BW'(len_ff - cur_ff);
                           end
                        end
                     end
                     default: ;
                  endcase
               end
               rep_in = j_rep;
               total  = TW'(plen_in) * TW'(j_rep) + TW'(lend_in - lidx_in)
                        + TW'(mid_in) + TW'(j_bs);
               rem_in = total;
               if (copy_go) begin
                  st_in = ST_COPY;
               end else if (total == '0) begin
                  st_in = ST_IDLE;
               end else if (j_rep != '0) begin
                  st_in = ST_PRE;
               end else if (lidx_in != lend_in) begin
                  st_in = ST_LINE;
               end else if (mid_in) begin
                  st_in = ST_MID;
               end else begin
                  st_in = ST_BS;
               end
            end
         end
         ST_COPY: begin
            push_en = 1'b1;
            if (lidx_ff == len_ff - 1'b1) begin
               len_in  = '0;
               lidx_in = '0;
               st_in   = (rem_ff != '0) ? ST_PRE : ST_IDLE;
            end else begin
               lidx_in = lidx_ff + 1'b1;
            end
         end
         ST_PRE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = kind_ff;
               emit_byte = pre_ff[pidx_ff];
               if (pidx_ff == plen_ff - 2'd1) begin
                  pidx_in = 2'd0;
                  rep_in  = rep_ff - 1'b1;
                  if (rem_ff == TW'(1)) begin
                     st_in = ST_IDLE;
                  end else if (rep_ff == IW'(1)) begin
                     if (lidx_ff != lend_ff) begin
                        st_in = ST_LINE;
                     end else if (mid_ff) begin
                        st_in = ST_MID;
                     end else begin
                        st_in = ST_BS;
                     end
                  end
               end else begin
                  pidx_in = pidx_ff + 2'd1;
               end
            end
         end
         ST_LINE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = line_rd;
               lidx_in   = lidx_ff + 1'b1;
               if (rem_ff == TW'(1)) begin
                  st_in = ST_IDLE;
               end else if (lidx_ff + 1'b1 == lend_ff) begin
                  st_in = mid_ff ? ST_MID : ST_BS;
               end
            end
         end
         ST_MID: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = tle_pkg::CH_SPACE;
               st_in     = (rem_ff == TW'(1)) ? ST_IDLE : ST_BS;
            end
         end
         ST_BS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = tle_pkg::CH_BS;
               if (rem_ff == TW'(1)) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   // one result per cycle into the output register while rsp is not stalled
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in        = 1'b1;
         out_in.out_kind     = emit_kind;
         out_in.out_byte     = emit_byte;
         out_in.last         = (rem_ff == TW'(1));
         out_in.ready_flag   = rdy_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign head_in = (push_en && head_nx != tail_ff) ? head_nx : head_ff;

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      pre_ff  <= pre_in;
      plen_ff <= plen_in;
      pidx_ff <= pidx_in;
      rep_ff  <= rep_in;
      kind_ff <= kind_in;
      lidx_ff <= lidx_in;
      lend_ff <= lend_in;
      mid_ff  <= mid_in;
      rem_ff  <= rem_in;
      out_ff  <= out_in;
      if (push_en && head_nx != tail_ff) begin
         ring_ff[head_ff] <= push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         esc_ff       <= ESC_NORMAL;
         rdy_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         esc_ff       <= esc_in;
         rdy_ff       <= rdy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `TLE_ASSERT(a_state_onehot, $onehot(st_ff), "sequencer state not one-hot")
   `TLE_ASSERT(a_cursor_in_line, cur_ff <= len_ff, "cursor beyond line end")
   `TLE_IMPLY(a_emit_pending, (st_ff != ST_IDLE) && (st_ff != ST_COPY), rem_ff != '0, "echo phase with nothing left")
   `TLE_NEXT(a_last_ends_job, emit && (rem_ff == TW'(1)), st_ff == ST_IDLE, "job continues after last result")

endmodule
`default_nettype wire

>>> rtl/terminal_line_editor.sv
// Channel  Ports                         Direction  Payload
// req      req_valid/req_ready/req_data  in         op, char_code
// rsp      rsp_valid/rsp_ready/rsp_data  out        out_kind, out_byte, last, ready_flag
// csr      csr_we/csr_index/csr_wdata    in         canonical_mode, echo_enable, focused
//
// An item is accepted in the idle state, then its results are emitted; Enter first copies
// each line byte into the ring. The back end takes no new item until it is back in idle.
// The echo sequencer in the back end emits one result per cycle unless rsp stalls.
// A two-entry queue lets the front take items while the back end works.
// Synchronous active-high reset; the line store and ring hold no reset value.
// A stalled rsp holds the sequencer; req stalls only when the queue is full.
`default_nettype none
module terminal_line_editor #(
   parameter int BUF_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  tle_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output tle_pkg::rsp_type  rsp_data,
   input  wire               csr_we,
   input  wire [1:0]         csr_index,
   input  wire               csr_wdata
);

   logic             cmd_valid, cmd_ready;
   tle_pkg::cmd_type cmd;

   tle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   tle_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> bench/tb_top.sv
module tb_top;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tle_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tle_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = tle_pkg::CSR_CANONICAL;
   logic csr_wdata = 1'b0;

   terminal_line_editor #(.BUF_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // editor model state
   logic mode_canon, mode_echo, mode_focus;
   logic [7:0] line_buf [DEPTH];
   logic [7:0] ring_buf [DEPTH];
   int line_len, cursor, esc_phase, ring_head, ring_tail;
   logic rdy_model;

   tle_pkg::rsp_type pending_rsp[$];
   tle_pkg::rsp_type step_rsp[$];

   int fail_count = 0;
   int key_count = 0, read_count = 0, rsp_count = 0;
   int idle_send = 0, idle_recv = 0;
   int quiet_cycles = 0;

   task automatic emit_rsp(input logic [1:0] kind, input logic [7:0] b);
      tle_pkg::rsp_type r;
      r = '0;
      r.out_kind = kind;
      r.out_byte = b;
      step_rsp.push_back(r);
   endtask

   task automatic echo_char(input logic [7:0] b);
      if (mode_echo && mode_focus) emit_rsp(tle_pkg::KIND_ECHO, b);
   endtask

   task automatic echo_move(input logic [7:0] letter);
      echo_char(tle_pkg::CH_ESC);
      echo_char(tle_pkg::CH_LBRACK);
      echo_char(letter);
   endtask

   task automatic ring_push(input logic [7:0] b);
      int nxt;
      nxt = (ring_head + 1) % DEPTH;
      if (nxt != ring_tail) begin
         ring_buf[ring_head] = b;
         ring_head = nxt;
      end
   endtask

   task automatic edit_key(input logic [7:0] c);
      int i;
      if (esc_phase == 1) begin
         esc_phase = (c == tle_pkg::CH_LBRACK) ? 2 : 0;
      end else if (esc_phase == 2) begin
         esc_phase = 0;
         if (c == tle_pkg::CH_UC_C || c == tle_pkg::CH_UC_F) begin
            while (cursor < line_len) begin
               cursor++;
               echo_move(tle_pkg::CH_UC_C);
               if (c == tle_pkg::CH_UC_C) break;
            end
         end else if (c == tle_pkg::CH_UC_D || c == tle_pkg::CH_UC_H) begin
            while (cursor > 0) begin
               cursor--;
               echo_move(tle_pkg::CH_UC_D);
               if (c == tle_pkg::CH_UC_D) break;
            end
         end
      end else if (c == tle_pkg::CH_ESC) begin
         esc_phase = 1;
      end else if (c == tle_pkg::CH_LF || c == tle_pkg::CH_CR) begin
         if (line_len < DEPTH - 1) begin
            line_buf[line_len] = tle_pkg::CH_LF;
            line_len++;
         end
         for (i = 0; i < line_len; i++) ring_push(line_buf[i]);
         line_len = 0;
         cursor = 0;
         rdy_model = 1'b1;
         echo_char(tle_pkg::CH_LF);
      end else if (c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL) begin
         if (cursor > 0 && cursor <= line_len) begin
            for (i = cursor - 1; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
            line_len--;
            cursor--;
            echo_char(tle_pkg::CH_BS);
            for (i = cursor; i < line_len; i++) echo_char(line_buf[i]);
            echo_char(tle_pkg::CH_SPACE);
            for (i = cursor; i <= line_len; i++) echo_char(tle_pkg::CH_BS);
         end
      end else if (c == tle_pkg::CH_INTR) begin
         line_len = 0;
         cursor = 0;
         echo_char(tle_pkg::CH_CARET);
         echo_char(tle_pkg::CH_UC_C);
         echo_char(tle_pkg::CH_LF);
      end else if (c == tle_pkg::CH_FF) begin
         if (mode_focus) emit_rsp(tle_pkg::KIND_CLEAR, 8'h00);
      end else if (c >= tle_pkg::CH_SPACE && c < tle_pkg::CH_DEL) begin
         if (line_len < DEPTH - 1 && cursor <= line_len) begin
            for (i = line_len; i > cursor; i--) line_buf[i] = line_buf[i - 1];
            line_buf[cursor] = c;
            line_len++;
            cursor++;
            for (i = cursor - 1; i < line_len; i++) echo_char(line_buf[i]);
            for (i = cursor; i < line_len; i++) echo_char(tle_pkg::CH_BS);
         end
      end
   endtask

   task automatic pop_ring();
      if (mode_canon && !rdy_model) begin
         emit_rsp(tle_pkg::KIND_EMPTY, 8'h00);
      end else begin
         if (ring_tail == ring_head) begin
            emit_rsp(tle_pkg::KIND_EMPTY, 8'h00);
         end else begin
            emit_rsp(tle_pkg::KIND_READ, ring_buf[ring_tail]);
            ring_tail = (ring_tail + 1) % DEPTH;
         end
         if (mode_canon && ring_tail == ring_head) rdy_model = 1'b0;
      end
   endtask

   task automatic predict_editor(input tle_pkg::req_type item);
      tle_pkg::rsp_type r;
      step_rsp.delete();
      if (item.op == tle_pkg::OP_READ) begin
         pop_ring();
      end else if (mode_canon) begin
         edit_key(item.char_code);
      end else begin
         ring_push(item.char_code);
         if (item.char_code >= tle_pkg::CH_SPACE && item.char_code < tle_pkg::CH_DEL) begin
            echo_char(item.char_code);
         end
      end
      foreach (step_rsp[k]) begin
         r = step_rsp[k];
         r.last = (k == step_rsp.size() - 1);
         r.ready_flag = rdy_model;
         pending_rsp.push_back(r);
      end
   endtask

   // idling mode: 0 none, 1 sender, 2 receiver, 3 both
   int idle_mode = 0;

   function automatic bit idle_now(input bit sender_side);
      int pct;
      pct = (idle_mode == 3) ? 35 : 49;
      if (idle_mode == 0) return 0;
      if (idle_mode == 1 && !sender_side) return 0;
      if (idle_mode == 2 && sender_side) return 0;
      return $urandom_range(99) < pct;
   endfunction

   // valid stays up after a transfer until the next item or a pause replaces it
   task automatic send_item(input logic op, input logic [7:0] c);
      tle_pkg::req_type item;
      item.op = op;
      item.char_code = c;
      if (idle_now(1)) begin
         req_valid <= 1'b0;
         do begin
            idle_send++;
            @(posedge clock);
         end while (idle_now(1));
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_editor(item);
      if (op == tle_pkg::OP_READ) read_count++;
      else key_count++;
   endtask

   task automatic key(input logic [7:0] c);
      send_item(tle_pkg::OP_KEY, c);
   endtask

   task automatic read_byte();
      send_item(tle_pkg::OP_READ, 8'h00);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic v);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         tle_pkg::CSR_CANONICAL: mode_canon = v;
         tle_pkg::CSR_ECHO:      mode_echo = v;
         default:                mode_focus = v;
      endcase
   endtask

   // response side
   always @(posedge clock) begin
      tle_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               $error("unexpected result kind %0d byte %02h", rsp_data.out_kind,
                      rsp_data.out_byte);
               fail_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_data.out_kind !== exp_rsp.out_kind) begin
                  $error("out_kind exp %0d got %0d", exp_rsp.out_kind, rsp_data.out_kind);
                  fail_count++;
               end
               if (rsp_data.out_byte !== exp_rsp.out_byte) begin
                  $error("out_byte exp %02h got %02h", exp_rsp.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.last !== exp_rsp.last) begin
                  $error("last exp %0b got %0b", exp_rsp.last, rsp_data.last);
                  fail_count++;
               end
               if (rsp_data.ready_flag !== exp_rsp.ready_flag) begin
                  $error("ready_flag exp %0b got %0b", exp_rsp.ready_flag,
                         rsp_data.ready_flag);
                  fail_count++;
               end
            end
         end
         if (idle_now(0)) begin
            idle_recv++;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic test_line_editing();
      int i;
      // full line, overflow ignored
      for (i = 0; i < 16; i++) key(8'h41 + i[7:0]);
      key(tle_pkg::CH_ESC); key(tle_pkg::CH_LBRACK); key(tle_pkg::CH_UC_H);
      key(tle_pkg::CH_ESC); key(tle_pkg::CH_LBRACK); key(tle_pkg::CH_UC_D);   // at home
      key(tle_pkg::CH_ESC); key(tle_pkg::CH_LBRACK); key(tle_pkg::CH_UC_C);
      key(tle_pkg::CH_DEL);
      key(tle_pkg::CH_BS);                                  // at home after delete
      key(8'h7E);
      key(tle_pkg::CH_ESC); key(tle_pkg::CH_LBRACK); key(tle_pkg::CH_UC_F);
      key(tle_pkg::CH_ESC); key(8'h41);                     // ESC then non-bracket
      key(tle_pkg::CH_ESC); key(tle_pkg::CH_LBRACK); key(8'h33);
      key(tle_pkg::CH_FF);
      key(8'h80); key(8'hFF); key(8'h01);
      key(tle_pkg::CH_LF);
      for (i = 0; i < 3; i++) read_byte();
   endtask

   task automatic test_intr_and_reads();
      read_byte();                                 // ready before drain
      key(8'h20); key(tle_pkg::CH_INTR);
      key(8'h61); key(tle_pkg::CH_CR);
      // ring fills and drops
      key(8'h62); key(8'h63); key(tle_pkg::CH_LF);
      repeat (20) read_byte();
   endtask

   task automatic test_config(input logic canon, input logic echo_on, input logic focus,
                              input int n_items);
      int i;
      logic [7:0] c;
      write_csr(tle_pkg::CSR_CANONICAL, canon);
      write_csr(tle_pkg::CSR_ECHO, echo_on);
      write_csr(tle_pkg::CSR_FOCUSED, focus);
      for (i = 0; i < n_items; i++) begin
         case ($urandom_range(9))
            0, 1: read_byte();
            2: begin
               key(tle_pkg::CH_ESC); key(tle_pkg::CH_LBRACK);
               case ($urandom_range(5))
                  0: key(tle_pkg::CH_UC_C);
                  1: key(tle_pkg::CH_UC_D);
                  2: key(tle_pkg::CH_UC_H);
                  3: key(tle_pkg::CH_UC_F);
                  default: key(8'($urandom_range(255)));
               endcase
            end
            3: key($urandom_range(1) ? tle_pkg::CH_LF : tle_pkg::CH_CR);
            4: key($urandom_range(1) ? tle_pkg::CH_BS : tle_pkg::CH_DEL);
            5: key($urandom_range(9) == 0 ? tle_pkg::CH_INTR : tle_pkg::CH_FF);
            6: key(8'($urandom_range(255)));
            default: begin
               c = 8'($urandom_range(32, 126));
               key(c);
            end
         endcase
      end
   endtask

   initial begin
      mode_canon = 1'b1;
      mode_echo = 1'b1;
      mode_focus = 1'b1;
      line_len = 0; cursor = 0; esc_phase = 0;
      ring_head = 0; ring_tail = 0;
      rdy_model = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_mode = 0;
      test_line_editing();
      test_intr_and_reads();
      wait_drained();                              // sender holds off until drained
      idle_mode = 1;
      test_config(1'b1, 1'b1, 1'b1, 14);
      idle_mode = 2;
      test_config(1'b0, 1'b1, 1'b1, 10);
      idle_mode = 3;
      test_config(1'b1, 1'b0, 1'b1, 8);
      test_config(1'b0, 1'b1, 1'b0, 6);
      idle_mode = 0;
      test_config(1'b1, 1'b1, 1'b1, 8);
      wait_drained();

      $display("covered %0d keys, %0d reads, %0d results; canonical and raw, echo and focus",
               key_count, read_count, rsp_count);
      $display("sender idled %0d cycles, receiver stalled %0d cycles", idle_send, idle_recv);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
